### src/dhhs_pkg.sv
// Shared types and constants for the dual hand home-and-seek controller.
// Used by every module of the block and by its checker.
package dhhs_pkg;

   localparam int STEPS_PER_REV_DEF = 51200;
   localparam int SECS_PER_REV      = 60 * 60 * 1;

   localparam int REMAIN_W = 17;
   localparam int OFS_W    = 12;
   localparam int SUM_W    = REMAIN_W + 1;
   localparam logic [REMAIN_W-1:0] REMAIN_MAX = {REMAIN_W{1'b1}};

   // offset scaling: floor(x / 3600) as floor(floor(x / 16) * RECIP / 2^28), x < 2^24
   localparam int FRAC_W    = 24;
   localparam int RECIP_W   = 21;
   localparam int PROD_W    = FRAC_W - 4 + RECIP_W;
   localparam int RECIP_SH  = 28;
   localparam logic [RECIP_W-1:0] OFS_RECIP = 21'd1193047;
   localparam logic [FRAC_W-1:0]  OFS_HALF  = 24'd1800;

   // request codes
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_HOME = 2'd1;
   localparam logic [1:0] REQ_SEEK = 2'd2;

   // mode codes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_HOME = 2'd1;
   localparam logic [1:0] MODE_SEEK = 2'd2;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOUR_OFFSET   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINUTE_OFFSET = 1'b1;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic [5:0] second_of_minute;
      logic       minute_switch;
      logic       hour_switch;
   } req_item_type;

   typedef struct packed {
      logic       minute_step;
      logic       hour_step;
      logic [1:0] mode;
   } rsp_item_type;

   // scaled offsets handed from the offset unit to the controller
   typedef struct packed {
      logic                busy;
      logic [REMAIN_W-1:0] hour_steps;
      logic [REMAIN_W-1:0] minute_steps;
   } ofs_status_type;

endpackage

### src/dhhs_offset.sv
// Offset registers and their conversion from seconds of a revolution to steps.
// Depends on dhhs_pkg. Two register stages after each write; busy covers them.
module dhhs_offset #(
   parameter int STEPS_PER_REV = dhhs_pkg::STEPS_PER_REV_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dhhs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dhhs_pkg::OFS_W-1:0]           csr_wdata,
   output dhhs_pkg::ofs_status_type             ofs
);
   import dhhs_pkg::*;

   // steps = off * A + floor((off * B + 1800) / 3600), with R = 3600 * A + B
   localparam logic [4:0]       OFF_A  = 5'(STEPS_PER_REV / SECS_PER_REV);
   localparam logic [OFS_W-1:0] OFF_B  = OFS_W'(STEPS_PER_REV % SECS_PER_REV);
   localparam logic [1:0]       SETTLE = 2'd2;

   logic [OFS_W-1:0]    off_ff   [2];
   logic [REMAIN_W-1:0] base_ff  [2];
   logic [FRAC_W-1:0]   frac_ff  [2];
   logic [REMAIN_W-1:0] map_ff   [2];
   logic [PROD_W-1:0]   prod     [2];
   logic [OFS_W-1:0]    quot     [2];
   logic [1:0]          settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         settle_ff <= SETTLE;
      end else begin
         if (csr_we) begin
            off_ff[csr_index] <= csr_wdata;
            settle_ff         <= SETTLE;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   always_comb begin
      for (int h = 0; h < 2; h++) begin
         prod[h] = PROD_W'(frac_ff[h][FRAC_W-1:4]) * PROD_W'(OFS_RECIP);
         quot[h] = prod[h][RECIP_SH+OFS_W-1:RECIP_SH];
      end
   end

   always_ff @(posedge clock) begin
      for (int h = 0; h < 2; h++) begin
         base_ff[h] <= REMAIN_W'(off_ff[h]) * REMAIN_W'(OFF_A);
         frac_ff[h] <= FRAC_W'(off_ff[h]) * FRAC_W'(OFF_B) + OFS_HALF;
         map_ff[h]  <= base_ff[h] + REMAIN_W'(quot[h]);
      end
   end

   assign ofs.busy         = (settle_ff != 2'd0);
   assign ofs.hour_steps   = map_ff[CSR_HOUR_OFFSET];
   assign ofs.minute_steps = map_ff[CSR_MINUTE_OFFSET];

endmodule

### src/dhhs_ctrl.sv
// Hand state: homing flags, seek step counts and the phase, updated per transfer.
// Depends on dhhs_pkg and the scaled offsets from dhhs_offset.
module dhhs_ctrl #(
   parameter int STEPS_PER_REV = dhhs_pkg::STEPS_PER_REV_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  dhhs_pkg::req_item_type     req,
   input  dhhs_pkg::ofs_status_type   ofs,
   output dhhs_pkg::rsp_item_type     rsp_next
);
   import dhhs_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_HOME, PH_SEEK} phase_type;
   typedef logic [REMAIN_W-1:0] tab32_type [32];
   typedef logic [REMAIN_W-1:0] tab64_type [64];

   function automatic tab32_type hour_tab();
      tab32_type t;
      for (int i = 0; i < 32; i++)
         t[i] = REMAIN_W'((2 * (i % 12) * STEPS_PER_REV + 12) / 24);
      return t;
   endfunction

   function automatic tab64_type hour_min_tab();
      tab64_type t;
      for (int i = 0; i < 64; i++)
         t[i] = REMAIN_W'((2 * i * (STEPS_PER_REV / 12) + 60) / 120);
      return t;
   endfunction

   function automatic tab64_type min_tab();
      tab64_type t;
      for (int i = 0; i < 64; i++)
         t[i] = REMAIN_W'((2 * i * STEPS_PER_REV + 60) / 120);
      return t;
   endfunction

   function automatic tab64_type sec_tab();
      tab64_type t;
      for (int i = 0; i < 64; i++)
         t[i] = REMAIN_W'((2 * i * ((STEPS_PER_REV / 60) / 60) + 60) / 120);
      return t;
   endfunction

   localparam tab32_type HOUR_TAB     = hour_tab();
   localparam tab64_type HOUR_MIN_TAB = hour_min_tab();
   localparam tab64_type MIN_TAB      = min_tab();
   localparam tab64_type SEC_TAB      = sec_tab();

   phase_type           phase_ff, phase_in;
   logic                first_ff, first_in;
   logic                mlev_ff, mlev_in, hlev_ff, hlev_in;
   logic                mclr_ff, mclr_in, hclr_ff, hclr_in;
   logic                mrun_ff, mrun_in, hrun_ff, hrun_in;
   logic [REMAIN_W-1:0] mrem_ff, mrem_in, hrem_ff, hrem_in;
   logic [SUM_W-1:0]    hour_sum, minute_sum;
   logic [REMAIN_W-1:0] hour_cnt, minute_cnt;
   logic                mstep, hstep;

   always_comb begin
      hour_sum   = SUM_W'(HOUR_TAB[req.hour_of_day])
                 + SUM_W'(HOUR_MIN_TAB[req.minute_of_hour])
                 + SUM_W'(ofs.hour_steps);
      minute_sum = SUM_W'(MIN_TAB[req.minute_of_hour])
                 + SUM_W'(SEC_TAB[req.second_of_minute])
                 + SUM_W'(ofs.minute_steps);
      hour_cnt   = hour_sum[SUM_W-1]   ? REMAIN_MAX : hour_sum[REMAIN_W-1:0];
      minute_cnt = minute_sum[SUM_W-1] ? REMAIN_MAX : minute_sum[REMAIN_W-1:0];

      phase_in = phase_ff;
      first_in = first_ff;
      mlev_in  = mlev_ff;
      hlev_in  = hlev_ff;
      mclr_in  = mclr_ff;
      hclr_in  = hclr_ff;
      mrun_in  = mrun_ff;
      hrun_in  = hrun_ff;
      mrem_in  = mrem_ff;
      hrem_in  = hrem_ff;
      mstep    = 1'b0;
      hstep    = 1'b0;

      case (req.req_type)
         REQ_HOME: begin
            phase_in = PH_HOME;
            first_in = 1'b1;
            mlev_in  = 1'b0;
            hlev_in  = 1'b0;
            mclr_in  = 1'b0;
            hclr_in  = 1'b0;
            mrun_in  = 1'b1;
            hrun_in  = 1'b1;
            mrem_in  = '0;
            hrem_in  = '0;
         end
         REQ_SEEK: begin
            hrem_in  = hour_cnt;
            mrem_in  = minute_cnt;
            hrun_in  = (hour_cnt != '0);
            mrun_in  = (minute_cnt != '0);
            phase_in = (hrun_in || mrun_in) ? PH_SEEK : PH_IDLE;
         end
         REQ_TICK: begin
            if (phase_ff == PH_HOME) begin
               mstep = mrun_ff;
               hstep = hrun_ff;
               // first tick latches the starting switch levels
               if (first_ff) begin
                  first_in = 1'b0;
                  mlev_in  = req.minute_switch;
                  hlev_in  = req.hour_switch;
               end
               if (mlev_in || req.minute_switch) mclr_in = 1'b1;
               if (hlev_in || req.hour_switch)   hclr_in = 1'b1;
               if (mclr_in && !req.minute_switch) mrun_in = 1'b0;
               if (hclr_in && !req.hour_switch)   hrun_in = 1'b0;
               if (!mrun_in && !hrun_in) phase_in = PH_IDLE;
            end else if (phase_ff == PH_SEEK) begin
               // a stopped hand keeps its count
               if (mrun_ff) begin
                  mstep = 1'b1;
                  if (mrem_ff != '0) mrem_in = mrem_ff - 1'b1;
                  if (mrem_in == '0) mrun_in = 1'b0;
               end
               if (hrun_ff) begin
                  hstep = 1'b1;
                  if (hrem_ff != '0) hrem_in = hrem_ff - 1'b1;
                  if (hrem_in == '0) hrun_in = 1'b0;
               end
               if (!mrun_in && !hrun_in) phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase

      rsp_next.minute_step = mstep;
      rsp_next.hour_step   = hstep;
      unique case (phase_in)
         PH_IDLE: rsp_next.mode = MODE_IDLE;
         PH_HOME: rsp_next.mode = MODE_HOME;
         PH_SEEK: rsp_next.mode = MODE_SEEK;
         default: rsp_next.mode = MODE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         first_ff <= 1'b1;
         mlev_ff  <= 1'b0;
         hlev_ff  <= 1'b0;
         mclr_ff  <= 1'b0;
         hclr_ff  <= 1'b0;
         mrun_ff  <= 1'b0;
         hrun_ff  <= 1'b0;
         mrem_ff  <= '0;
         hrem_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         mlev_ff  <= mlev_in;
         hlev_ff  <= hlev_in;
         mclr_ff  <= mclr_in;
         hclr_ff  <= hclr_in;
         mrun_ff  <= mrun_in;
         hrun_ff  <= hrun_in;
         mrem_ff  <= mrem_in;
         hrem_ff  <= hrem_in;
      end
   end

endmodule

### src/dual_hand_home_and_seek.sv
// Dual hand home-and-seek controller for an hour and a minute stepper hand.
// Requests arrive on req_valid/req_ready with a req_data item: a tick, a start
// of homing, or a start of seek with the time of day. Every accepted request
// gives exactly one response on rsp_valid/rsp_ready: the step pulses for the
// two hands on that tick and the mode after the request.
// The response sits in the output register in the cycle after the transfer.
// One request is taken per cycle while no offset write settles and the output
// register is free; the output register takes a new response in the cycle it
// is drained, so req_ready follows rsp_ready when a response is waiting.
// The offsets are written on csr_we/csr_index/csr_wdata. Each write feeds a
// two-stage multiply pipeline that turns seconds of a revolution into steps;
// req_ready stays low after a write while it settles.
// A synchronous reset clears the hand state to idle, zeroes both offsets and
// drops any pending response; req_ready rises after reset ends, once settled.
// While rsp_ready is low a response is held and no further request is taken.
// Depends on dhhs_pkg, dhhs_offset and dhhs_ctrl.
module dual_hand_home_and_seek #(
   parameter int STEPS_PER_REV = dhhs_pkg::STEPS_PER_REV_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dhhs_pkg::req_item_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dhhs_pkg::rsp_item_type             rsp_data,
   input  logic                               csr_we,
   input  logic [dhhs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dhhs_pkg::OFS_W-1:0]         csr_wdata
);
   import dhhs_pkg::*;

   ofs_status_type ofs;
   rsp_item_type   rsp_in, rsp_ff;
   logic           rsp_valid_ff;
   logic           accept;

   assign req_ready = !ofs.busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   dhhs_offset #(.STEPS_PER_REV(STEPS_PER_REV)) u_offset (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ofs       (ofs)
   );

   dhhs_ctrl #(.STEPS_PER_REV(STEPS_PER_REV)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .ofs      (ofs),
      .rsp_next (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the response until its transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/dhhs_checker.sv
// Port-level checks for the dual hand home-and-seek controller.
// Depends on dhhs_pkg; attached to the top level by the bind at the end.
module dhhs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input dhhs_pkg::req_item_type             req_data,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input dhhs_pkg::rsp_item_type             rsp_data,
   input logic                               csr_we
);
   import dhhs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after a request transfer");

   a_start_no_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.req_type == REQ_HOME || req_data.req_type == REQ_SEEK)
      |=> !rsp_data.minute_step && !rsp_data.hour_step)
      else $error("step issued on a start request");

   a_home_mode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.req_type == REQ_HOME |=> rsp_data.mode == MODE_HOME)
      else $error("homing start did not report homing mode");

   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request taken before offsets settled");

endmodule

bind dual_hand_home_and_seek dhhs_checker u_dhhs_checker (.*);
